// ----- src/rbp_pkg.sv -----
// rbp_pkg: shared types, constants and helpers for the rice bit packer
// used by rbp_front, rbp_back and the top level; no dependencies
`default_nettype none

package rbp_pkg;

   // fixed field widths
   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 6;
   localparam int BYTE_W   = 8;
   // room for a unary run up to 1024 zeros and a pending bit total up to 1057
   localparam int ZEROS_W  = 11;
   localparam int REM_W    = 11;

   localparam logic [OPCODE_W-1:0] OP_RAW   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_UNARY = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RICE  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLOSE = 2'd3;

   typedef enum logic [1:0] {
      CMD_DATA,
      CMD_CLOSE,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [ZEROS_W-1:0]   zeros;
      logic                 one_bit;
      logic [COUNT_W-1:0]   raw_left;
      logic [VALUE_W-1:0]   raw_bits;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              error;
      logic              last;
   } rsp_type;

   function automatic logic [BYTE_W-1:0] mirror_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = b[BYTE_W-1-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/rbp_fifo.sv -----
// rbp_fifo: small register queue, used between front and back and on the result side
// no package dependencies
`default_nettype none

module rbp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/rbp_front.sv -----
// rbp_front: classifies an incoming transaction into a bit-writing command
// depends on rbp_pkg
`default_nettype none

module rbp_front
   import rbp_pkg::*;
#(
   parameter int MAX_QUOTIENT = 32,
   parameter int MAX_BITS     = 32
) (
   input  wire logic [OPCODE_W-1:0] opcode,
   input  wire logic [VALUE_W-1:0]  value,
   input  wire logic [COUNT_W-1:0]  count,
   output cmd_type                  cmd
);
   logic [COUNT_W-1:0] n;
   logic [VALUE_W-1:0] quot;
   logic               unary_long;
   logic               rice_long;

   // raw count and rice k saturate at MAX_BITS
   assign n          = (count > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : count;
   assign quot       = (n >= COUNT_W'(VALUE_W)) ? '0 : (value >> n);
   assign unary_long = (value > VALUE_W'(MAX_QUOTIENT));
   assign rice_long  = (quot > VALUE_W'(MAX_QUOTIENT));

   always_comb begin
      cmd.kind     = CMD_DATA;
      cmd.zeros    = '0;
      cmd.one_bit  = 1'b0;
      cmd.raw_left = '0;
      cmd.raw_bits = value;
      case (opcode)
         OP_RAW: begin
            cmd.raw_left = n;
         end
         OP_UNARY: begin
            if (unary_long) begin
               cmd.kind = CMD_ERROR;
            end else begin
               cmd.zeros   = ZEROS_W'(value);
               cmd.one_bit = 1'b1;
            end
         end
         OP_RICE: begin
            if (rice_long) begin
               cmd.kind = CMD_ERROR;
            end else begin
               cmd.zeros    = ZEROS_W'(quot);
               cmd.one_bit  = 1'b1;
               cmd.raw_left = n;
            end
         end
         OP_CLOSE: begin
            cmd.kind = CMD_CLOSE;
         end
         default: begin
            cmd.kind = CMD_CLOSE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/rbp_back.sv -----
// rbp_back: executes commands into the one-byte packing register and emits bytes
// depends on rbp_pkg
`default_nettype none

module rbp_back
   import rbp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    reverse,
   input  wire cmd_type cmd,
   input  wire logic    cmd_valid,
   output logic         cmd_pop,
   output rsp_type      rsp,
   output logic         rsp_push,
   input  wire logic    rsp_full
);
   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type          state_ff, state_in;
   cmd_kind_type       kind_ff, kind_in;
   logic [ZEROS_W-1:0] zeros_ff, zeros_in;
   logic               one_ff, one_in;
   logic [COUNT_W-1:0] raw_left_ff, raw_left_in;
   logic [VALUE_W-1:0] raw_bits_ff, raw_bits_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [BYTE_W-1:0]  pending_ff, pending_in;
   logic [2:0]         pos_ff, pos_in;

   logic [3:0]         free;
   logic [3:0]         take;
   logic [3:0]         new_pos;
   logic [BYTE_W-1:0]  raw_mask;
   logic [BYTE_W-1:0]  merged;
   logic [REM_W-1:0]   rem_after;

   assign free      = 4'd8 - {1'b0, pos_ff};
   assign raw_mask  = BYTE_W'((9'd1 << take) - 9'd1);
   assign new_pos   = {1'b0, pos_ff} + take;
   assign rem_after = rem_ff - REM_W'(take);

   // one source per cycle: unary zeros, then the terminating one, then raw bits
   always_comb begin
      if (zeros_ff != '0) begin
         take   = (zeros_ff < ZEROS_W'(free)) ? zeros_ff[3:0] : free;
         merged = pending_ff;
      end else if (one_ff) begin
         take   = 4'd1;
         merged = pending_ff | (BYTE_W'(1) << pos_ff);
      end else begin
         take   = (raw_left_ff < COUNT_W'(free)) ? raw_left_ff[3:0] : free;
         merged = pending_ff | ((raw_bits_ff[BYTE_W-1:0] & raw_mask) << pos_ff);
      end
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      zeros_in    = zeros_ff;
      one_in      = one_ff;
      raw_left_in = raw_left_ff;
      raw_bits_in = raw_bits_ff;
      rem_in      = rem_ff;
      pending_in  = pending_ff;
      pos_in      = pos_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               kind_in     = cmd.kind;
               zeros_in    = cmd.zeros;
               one_in      = cmd.one_bit;
               raw_left_in = cmd.raw_left;
               raw_bits_in = cmd.raw_bits;
               rem_in      = cmd.zeros + REM_W'(cmd.one_bit) + REM_W'(cmd.raw_left);
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            case (kind_ff)
               CMD_ERROR: begin
                  if (!rsp_full) begin
                     rsp_push  = 1'b1;
                     rsp.error = 1'b1;
                     rsp.last  = 1'b1;
                     state_in  = ST_IDLE;
                  end
               end
               CMD_CLOSE: begin
                  if (pos_ff == '0) begin
                     state_in = ST_IDLE;
                  end else if (!rsp_full) begin
                     rsp_push     = 1'b1;
                     rsp.out_byte = reverse ? mirror_byte(pending_ff) : pending_ff;
                     rsp.last     = 1'b1;
                     pending_in   = '0;
                     pos_in       = '0;
                     state_in     = ST_IDLE;
                  end
               end
               CMD_DATA: begin
                  if (rem_ff == '0) begin
                     state_in = ST_IDLE;
                  end else if (!(new_pos[3] && rsp_full)) begin
                     if (zeros_ff != '0) begin
                        zeros_in = zeros_ff - ZEROS_W'(take);
                     end else if (one_ff) begin
                        one_in = 1'b0;
                     end else begin
                        raw_left_in = raw_left_ff - COUNT_W'(take);
                        raw_bits_in = raw_bits_ff >> take;
                     end
                     rem_in = rem_after;
                     if (new_pos[3]) begin
                        rsp_push     = 1'b1;
                        rsp.out_byte = reverse ? mirror_byte(merged) : merged;
                        // no further byte can complete from what is left
                        rsp.last     = (rem_after < REM_W'(BYTE_W));
                        pending_in   = '0;
                        pos_in       = '0;
                     end else begin
                        pending_in = merged;
                        pos_in     = new_pos[2:0];
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= '0;
         pos_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         pos_ff     <= pos_in;
      end
      kind_ff     <= kind_in;
      zeros_ff    <= zeros_in;
      one_ff      <= one_in;
      raw_left_ff <= raw_left_in;
      raw_bits_ff <= raw_bits_in;
      rem_ff      <= rem_in;
   end

endmodule

`default_nettype wire

// ----- src/lsb_first_rice_bit_packer_top.sv -----
// lsb_first_rice_bit_packer_top: LSB-first bit packer with unary and rice codes
// instantiates rbp_front, rbp_fifo, rbp_back; depends on rbp_pkg
//
// Input side is a queue: a transaction (opcode, value, count) enters when req_push
// is high and req_full low. Results are read as a queue: while rsp_empty is low the
// oldest byte is on rsp_out_byte/rsp_error/rsp_last and leaves on rsp_pop.
// The front classifies each transaction into a command (raw bits, unary+raw run,
// close, or overflow error) and queues it in a 2-entry command queue; the back
// drains commands into a one-byte packing register and a 2-entry result queue.
// With the back idle, the first byte of a transaction passes from the command queue
// through the back's command and packing registers into the result queue.
// The back loads a command, then handles one chunk per step (a chunk is
// at most the free bits of the packing register, from one of: unary zeros, the
// terminating one, raw bits), and then retires it; close and error take a load and
// one step. The byte output rate tops out at one per cycle while the result queue
// has room; the back loop sets this limit. csr_ready is always high; the user must
// write reverse_output_bits only while idle, which the block itself does not enforce.
// Synchronous reset empties both queues, clears the packer and the register.
// When the receiver stalls, the result queue fills, the back holds, and then the
// command queue fills and req_full rises.
`default_nettype none

module lsb_first_rice_bit_packer_top
   import rbp_pkg::*;
#(
   parameter int MAX_QUOTIENT = 32,
   parameter int MAX_BITS     = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [OPCODE_W-1:0] req_opcode,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic [COUNT_W-1:0]  req_count,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [BYTE_W-1:0]        rsp_out_byte,
   output logic                     rsp_error,
   output logic                     rsp_last,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_reverse_output_bits
);
   logic    reverse_ff;
   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    cmd_empty;
   logic    cmd_pop;
   rsp_type back_rsp;
   rsp_type head_rsp;
   logic    rsp_push;
   logic    rsp_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         reverse_ff <= csr_reverse_output_bits;
      end
   end

   rbp_front #(
      .MAX_QUOTIENT(MAX_QUOTIENT),
      .MAX_BITS    (MAX_BITS)
   ) u_front (
      .opcode(req_opcode),
      .value (req_value),
      .count (req_count),
      .cmd   (front_cmd)
   );

   rbp_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(2)
   ) u_cmd_q (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .wr_data(front_cmd),
      .full   (req_full),
      .pop    (cmd_pop),
      .rd_data(back_cmd),
      .empty  (cmd_empty)
   );

   rbp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .reverse  (reverse_ff),
      .cmd      (back_cmd),
      .cmd_valid(!cmd_empty),
      .cmd_pop  (cmd_pop),
      .rsp      (back_rsp),
      .rsp_push (rsp_push),
      .rsp_full (rsp_full)
   );

   rbp_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(2)
   ) u_rsp_q (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(back_rsp),
      .full   (rsp_full),
      .pop    (rsp_pop),
      .rd_data(head_rsp),
      .empty  (rsp_empty)
   );

   assign rsp_out_byte = head_rsp.out_byte;
   assign rsp_error    = head_rsp.error;
   assign rsp_last     = head_rsp.last;

endmodule

`default_nettype wire

// ----- src/rbp_checker.sv -----
// rbp_checker: port-level assertions for lsb_first_rice_bit_packer_top, bound below
// no package dependencies
`default_nettype none

module rbp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_error,
   input wire logic       rsp_last
);

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // an error transaction yields one result; this checks that it has a zero byte and last set
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> (rsp_out_byte == 8'd0 && rsp_last))
      else $error("error result malformed");

   // a waiting result holds until popped
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_error) && $stable(rsp_last)))
      else $error("result head changed while stalled");

endmodule

bind lsb_first_rice_bit_packer_top rbp_checker u_rbp_checker (.*);

`default_nettype wire
